### rtl/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 16;

    localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 16'd4096;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ENC   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CONTROL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;

    localparam logic [CP_W-1:0] POINT_LIMIT    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURROGATE_LOW  = 21'h00D800;
    localparam logic [CP_W-1:0] SURROGATE_HIGH = 21'h00DFFF;

    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_TWO  = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_item;

    typedef struct packed {
        logic [CP_W-1:0]     code_point;
        logic [STATUS_W-1:0] status;
        logic                text_done;
    } t_result;

    function automatic logic [CP_W-1:0] class_minimum(input logic [1:0] mc);
        logic [CP_W-1:0] v;
        unique case (mc)
            CLASS_NONE:  v = 21'h000000;
            CLASS_TWO:   v = 21'h000080;
            CLASS_THREE: v = 21'h000800;
            CLASS_FOUR:  v = 21'h010000;
            default:     v = 21'h000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/u8d_in_if.sv
`timescale 1ns / 1ps

interface u8d_in_if
    import u8d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

### rtl/u8d_out_if.sv
`timescale 1ns / 1ps

interface u8d_out_if
    import u8d_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CP_W-1:0]     code_point;
    logic [STATUS_W-1:0] status;
    logic                text_done;

    modport source (output valid, output code_point, output status, output text_done,
                    input ready);
    modport sink   (input valid, input code_point, input status, input text_done,
                    output ready);
endinterface

### rtl/u8d_cfg_if.sv
`timescale 1ns / 1ps

interface u8d_cfg_if
    import u8d_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] max_characters;

    modport source (output valid, output max_characters, input ready);
    modport sink   (input valid, input max_characters, output ready);
endinterface

### rtl/utf8_validating_decoder.sv
`timescale 1ns / 1ps

// Strict UTF-8 decoder: one text byte per transaction in, at most one result
// per byte out (a code point on the byte that completes it, or one error
// result per text). Throughput is one byte per clock except while the input
// side stalls; a byte passes an input register, the decode logic, and an
// output register, which drives the result on the output. The input side
// stalls only while both the input and output registers hold data and the
// output is not ready.
// max_characters may be written only while no text is in flight.
module utf8_validating_decoder
    import u8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_in_if.sink    i_in,
    u8d_out_if.source o_out,
    u8d_cfg_if.sink   i_cfg
);

    logic               r_s1_valid;
    t_item              r_s1_item;
    logic [COUNT_W-1:0] r_max_chars;

    logic    free;
    logic    advance;
    logic    in_fire;
    logic    res_valid;
    t_result res;

    assign advance     = r_s1_valid && free;
    assign i_in.ready  = !r_s1_valid || advance;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_max_chars <= MAX_CHARS_RESET;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_max_chars <= i_cfg.max_characters;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item.text_byte   <= i_in.text_byte;
            r_s1_item.end_of_text <= i_in.end_of_text;
        end
    end

    u8d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (r_s1_item),
        .i_max_chars (r_max_chars),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    u8d_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .o_free  (free),
        .o_out   (o_out)
    );

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("input stage lost a stalled byte");

endmodule

### rtl/u8d_decode.sv
`timescale 1ns / 1ps

module u8d_decode
    import u8d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_item              i_item,
    input  logic [COUNT_W-1:0] i_max_chars,
    output logic               o_res_valid,
    output t_result            o_res
);

    logic [1:0]         r_pending, n_pending;
    logic [CP_W-1:0]    r_partial, n_partial;
    logic [1:0]         r_class, n_class;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_err, n_err;

    logic [BYTE_W-1:0]   b;
    logic                last;
    logic                have;
    logic [STATUS_W-1:0] status;
    logic [CP_W-1:0]     cp;
    logic [1:0]          mc;
    logic [CP_W-1:0]     shifted;

    always_comb begin
        n_pending   = r_pending;
        n_partial   = r_partial;
        n_class     = r_class;
        n_count     = r_count;
        n_err       = r_err;
        b           = i_item.text_byte;
        last        = i_item.end_of_text;
        have        = 1'b0;
        status      = ST_OK;
        cp          = '0;
        mc          = CLASS_NONE;
        shifted     = {r_partial[CP_W-7:0], b[5:0]};
        o_res_valid = 1'b0;

        if (!r_err) begin
            if (r_pending == 2'd0) begin
                if (!b[7]) begin
                    cp   = {{(CP_W-BYTE_W){1'b0}}, b};
                    have = 1'b1;
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    n_pending = 2'd1;
                    n_partial = {{(CP_W-5){1'b0}}, b[4:0]};
                    n_class   = CLASS_TWO;
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    n_pending = 2'd2;
                    n_partial = {{(CP_W-4){1'b0}}, b[3:0]};
                    n_class   = CLASS_THREE;
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    n_pending = 2'd3;
                    n_partial = {{(CP_W-3){1'b0}}, b[2:0]};
                    n_class   = CLASS_FOUR;
                end else begin
                    status = ST_BAD_ENC;
                end
            end else if (b[7:6] != 2'b10) begin
                status = ST_BAD_ENC;
            end else begin
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    cp        = shifted;
                    mc        = r_class;
                    have      = 1'b1;
                    n_partial = '0;
                    n_class   = CLASS_NONE;
                end else begin
                    n_partial = shifted;
                end
            end

            if (have) begin
                if (cp < class_minimum(mc) || cp > POINT_LIMIT ||
                    (cp >= SURROGATE_LOW && cp <= SURROGATE_HIGH)) begin
                    status = ST_BAD_ENC;
                end else if (cp < 21'd32 && cp != 21'd10 && cp != 21'd13 && cp != 21'd9) begin
                    status = ST_CONTROL;
                end else if (r_count >= i_max_chars) begin
                    status = ST_TOO_MANY;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else if (status == ST_OK && last) begin
                status = ST_TRUNCATED;
            end

            o_res_valid = have || (status != ST_OK);
            if (status != ST_OK) begin
                n_err = 1'b1;
            end
        end

        if (last) begin
            n_pending = 2'd0;
            n_partial = '0;
            n_class   = CLASS_NONE;
            n_count   = '0;
            n_err     = 1'b0;
        end

        o_res.code_point = (status == ST_OK) ? cp : '0;
        o_res.status     = status;
        o_res.text_done  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
            r_class   <= CLASS_NONE;
            r_count   <= '0;
            r_err     <= 1'b0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_class   <= n_class;
            r_count   <= n_count;
            r_err     <= n_err;
        end
    end

    a_class_tracks_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 2'd0) == (r_class == CLASS_NONE))
        else $error("sequence class out of step with pending count");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.end_of_text) |=>
            (r_pending == 2'd0 && r_count == '0 && !r_err))
        else $error("text state not cleared after last byte");

    a_no_result_when_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_res_valid)
        else $error("result produced after latched error");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_OK) |->
            (o_res.code_point <= POINT_LIMIT &&
             (o_res.code_point < SURROGATE_LOW || o_res.code_point > SURROGATE_HIGH)))
        else $error("accepted code point outside scalar range");

endmodule

### rtl/u8d_outbuf.sv
`timescale 1ns / 1ps

module u8d_outbuf
    import u8d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    u8d_out_if.source o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.code_point = r_res.code_point;
    assign o_out.status     = r_res.status;
    assign o_out.text_done  = r_res.text_done;

    a_error_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status != ST_OK) |-> (r_res.code_point == '0))
        else $error("error transaction carries a code point");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import u8d_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned REPORT_LIMIT  = 10;

    class utf8_reader;
        logic [COUNT_W-1:0] char_limit;
        logic [1:0]         conts_left;
        logic [CP_W-1:0]    partial;
        logic [1:0]         open_class;
        logic [COUNT_W-1:0] char_count;
        bit                 dropping;
        t_result            awaited_points[$];
        int unsigned        mismatch_count;

        function new();
            char_limit     = MAX_CHARS_RESET;
            mismatch_count = 0;
            clear_text();
        endfunction

        function void clear_text();
            conts_left = 2'd0;
            partial    = '0;
            open_class = CLASS_NONE;
            char_count = '0;
            dropping   = 1'b0;
        endfunction

        function void take_byte(input logic [BYTE_W-1:0] b, input logic last);
            t_result             r;
            logic [CP_W-1:0]     cp;
            logic [CP_W-1:0]     floor_point;
            logic [STATUS_W-1:0] st;
            logic [1:0]          cls;
            bit                  complete;
            st       = ST_OK;
            cp       = '0;
            cls      = CLASS_NONE;
            complete = 1'b0;
            if (dropping) begin
                if (last) clear_text();
                return;
            end
            if (conts_left == 2'd0) begin
                if (b < 8'h80) begin
                    cp       = {13'd0, b};
                    complete = 1'b1;
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    conts_left = 2'd1;
                    partial    = {16'd0, b[4:0]};
                    open_class = CLASS_TWO;
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    conts_left = 2'd2;
                    partial    = {17'd0, b[3:0]};
                    open_class = CLASS_THREE;
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    conts_left = 2'd3;
                    partial    = {18'd0, b[2:0]};
                    open_class = CLASS_FOUR;
                end else begin
                    st = ST_BAD_ENC;
                end
            end else if (b[7:6] != 2'b10) begin
                st = ST_BAD_ENC;
            end else begin
                partial    = {partial[CP_W-7:0], b[5:0]};
                conts_left = conts_left - 2'd1;
                if (conts_left == 2'd0) begin
                    cp         = partial;
                    cls        = open_class;
                    complete   = 1'b1;
                    partial    = '0;
                    open_class = CLASS_NONE;
                end
            end

            if (complete) begin
                case (cls)
                    CLASS_TWO:   floor_point = 21'h000080;
                    CLASS_THREE: floor_point = 21'h000800;
                    CLASS_FOUR:  floor_point = 21'h010000;
                    default:     floor_point = 21'h000000;
                endcase
                if (cp < floor_point || cp > POINT_LIMIT ||
                    (cp >= SURROGATE_LOW && cp <= SURROGATE_HIGH)) begin
                    st = ST_BAD_ENC;
                end else if (cp < 21'd32 && cp != 21'd10 && cp != 21'd13 &&
                             cp != 21'd9) begin
                    st = ST_CONTROL;
                end else if (char_count >= char_limit) begin
                    st = ST_TOO_MANY;
                end else begin
                    char_count = char_count + 1'b1;
                end
            end else if (st == ST_OK) begin
                if (!last) return;
                st = ST_TRUNCATED;
            end

            if (st != ST_OK) cp = '0;
            r.code_point = cp;
            r.status     = st;
            r.text_done  = last;
            awaited_points = {awaited_points, r};
            if (last) clear_text();
            else if (st != ST_OK) dropping = 1'b1;
        endfunction

        function void note_mismatch(input string what, input t_result want,
                                    input t_result got);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t %s: expected cp=%h st=%0d done=%b, got cp=%h st=%0d done=%b",
                         $time, what, want.code_point, want.status, want.text_done,
                         got.code_point, got.status, got.text_done);
        endfunction

        function void match_point(input t_result got);
            t_result want;
            if (awaited_points.size() == 0) begin
                want = '0;
                note_mismatch("unexpected result", want, got);
                return;
            end
            want = awaited_points.pop_front();
            if (got.code_point !== want.code_point || got.status !== want.status ||
                got.text_done !== want.text_done)
                note_mismatch("result mismatch", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8d_in_if  in_bus();
    u8d_out_if out_bus();
    u8d_cfg_if cfg_bus();

    utf8_reader reader = new();

    logic [BYTE_W-1:0] text_buf[$];
    int unsigned       burst_left = 0;
    int unsigned       bytes_sent = 0;
    int unsigned       idle_cycles = 0;
    logic [7:0]        ready_pattern = 8'hFF;
    int unsigned       pattern_pos = 0;

    utf8_validating_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (pattern_pos[5:0] == 6'd0)
            ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        out_bus.ready <= ready_pattern[pattern_pos[2:0]];
        pattern_pos++;
    end

    always @(posedge i_clk) begin
        t_result got;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1) begin
                reader.char_limit = cfg_bus.max_characters;
                moved = 1'b1;
            end
            if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
                reader.take_byte(in_bus.text_byte, in_bus.end_of_text);
                moved = 1'b1;
            end
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                got.code_point = out_bus.code_point;
                got.status     = out_bus.status;
                got.text_done  = out_bus.text_done;
                reader.match_point(got);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                in_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        in_bus.valid       <= 1'b1;
        in_bus.text_byte   <= b;
        in_bus.end_of_text <= last;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        burst_left = 0;
        while (reader.awaited_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] v);
        settle();
        @(negedge i_clk);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.max_characters <= v;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic void put_byte(input logic [BYTE_W-1:0] b);
        text_buf = {text_buf, b};
    endfunction

    function automatic void add_point(input logic [CP_W-1:0] cp);
        if (cp < 21'h80) begin
            put_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic int unsigned conts_for_lead(input logic [BYTE_W-1:0] lead);
        return (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
    endfunction

    function automatic void add_random_char();
        int unsigned       kind;
        logic [BYTE_W-1:0] lead;
        kind = $urandom_range(0, 15);
        if (kind <= 3) begin
            add_point(21'($urandom_range(32, 127)));
        end else if (kind == 4) begin
            add_point(21'($urandom_range(0, 31)));
        end else if (kind <= 7) begin
            add_point(21'($urandom_range('h80, 'h7FF)));
        end else if (kind <= 10) begin
            add_point(21'($urandom_range('h800, 'hFFFF)));
        end else if (kind <= 12) begin
            add_point(21'($urandom_range('h10000, 'h10FFFF)));
        end else if (kind == 13) begin
            put_byte(8'($urandom));
        end else if (kind == 14) begin
            lead = 8'($urandom_range('hC0, 'hFF));
            put_byte(lead);
            repeat (conts_for_lead(lead)) put_byte(8'($urandom_range('h80, 'hBF)));
        end else if ($urandom_range(0, 1) == 0) begin
            add_point(21'($urandom_range('hD800, 'hDFFF)));
        end else begin
            add_point(21'($urandom_range('h110000, 'h1FFFFF)));
        end
    endfunction

    task automatic send_random_text();
        int unsigned       chars;
        logic [BYTE_W-1:0] lead;
        chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        repeat (chars) add_random_char();
        if ($urandom_range(0, 7) == 0) begin
            lead = 8'($urandom_range('hC2, 'hF4));
            put_byte(lead);
            repeat ($urandom_range(0, conts_for_lead(lead) - 1))
                put_byte(8'($urandom_range('h80, 'hBF)));
        end
        send_text();
    endtask

    task automatic run_texts(input int unsigned n_bytes);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_random_text();
    endtask

    initial begin
        i_rst_n                = 1'b0;
        in_bus.valid           = 1'b0;
        in_bus.text_byte       = '0;
        in_bus.end_of_text     = 1'b0;
        out_bus.ready          = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.max_characters = MAX_CHARS_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        text_buf = '{8'h41};                   send_text();
        text_buf = '{8'h00};                   send_text();
        text_buf = '{8'hC0, 8'h41, 8'h42};     send_text();
        text_buf = '{8'hE0, 8'hA0};            send_text();
        text_buf = '{8'hC2, 8'h41};            send_text();
        text_buf = '{8'hED, 8'hA0, 8'h80};     send_text();
        text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_text();
        text_buf = '{8'h09, 8'h0A, 8'h0D, 8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();

        write_limit(16'd1);
        text_buf = '{8'h41, 8'h42};            send_text();

        write_limit(16'd3);
        run_texts(125);
        write_limit(16'hFFFF);
        run_texts(125);
        write_limit(16'd0);
        run_texts(60);
        write_limit(16'($urandom_range(1, 6)));
        run_texts(125);
        write_limit(16'd2);
        run_texts(125);
        write_limit(16'($urandom_range(1, 65535)));
        run_texts(125);
        write_limit(MAX_CHARS_RESET);
        run_texts(65);

        settle();
        if (reader.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
